### design/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 8;
    localparam int OCC_W   = 5;
    localparam int STAT_W  = 2;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Input item
    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] item_value;
        logic        [PRIO_W-1:0]  item_priority;
    } t_cmd;

    // Result item
    typedef struct packed {
        logic        [STAT_W-1:0]  status;
        logic signed [VALUE_W-1:0] head_value;
        logic        [PRIO_W-1:0]  head_priority;
        logic        [OCC_W-1:0]   occupancy;
    } t_result;

    // One stored entry
    typedef struct packed {
        logic signed [VALUE_W-1:0] item_value;
        logic        [PRIO_W-1:0]  item_priority;
    } t_entry;

    // Broadcast control to every cell
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } t_cell_ctl;

endpackage

### design/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of shifting cells plus control.
//
//  Channel   Ports                      Handshake
//  --------  -------------------------  -------------------------------------
//  command   start, busy, i_cmd         accepted when start && !busy
//  result    o_strobe, o_result         valid for one cycle while o_strobe
//
// The whole row of cells compares the new priority in parallel and shifts
// in the same clock edge, so an item may be accepted on every cycle while
// busy is low. The result appears on the cycle after accept.
// Reset (i_rst_n low, synchronous) empties the queue; busy is high during
// reset and up to the first edge that sees i_rst_n high, then stays low.
// The receiver cannot stall; each result is shown for exactly one cycle.
// An insert into a full queue leaves the cells untouched; so does a remove
// on an empty queue. Occupancy is reported modulo 32.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_busy;
    logic             r_strobe;
    t_result          r_result;
    t_result          n_result;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    t_cell_ctl        w_ctl;
    t_entry           w_new;
    t_entry           w_entry [DEPTH];
    logic             w_flag  [DEPTH];
    logic             w_occ   [DEPTH];
    logic [DEPTH-1:0] w_pair_ok;
    logic [CNT_W+OCC_W-1:0] w_occ_ext;

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    assign w_accept = start && !r_busy;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    // Broadcast control: a full insert or an empty remove changes nothing
    assign w_ctl.ins_en = w_accept && (i_cmd.kind == KIND_INSERT) && !w_full;
    assign w_ctl.rem_en = w_accept && (i_cmd.kind == KIND_REMOVE) && !w_empty;

    assign w_new.item_value    = i_cmd.item_value;
    assign w_new.item_priority = i_cmd.item_priority;

    // Row of cells, head at index zero
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_lflag;

        assign w_occ[gi] = (r_count > CNT_W'(gi));

        if (gi == 0) begin : g_head
            assign w_left  = w_new;
            assign w_lflag = 1'b0;
        end else begin : g_body
            assign w_left  = w_entry[gi-1];
            assign w_lflag = w_flag[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[gi+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (w_occ[gi]),
            .i_new       (w_new),
            .i_left      (w_left),
            .i_right     (w_right),
            .i_left_flag (w_lflag),
            .o_flag      (w_flag[gi]),
            .o_entry     (w_entry[gi])
        );

        // Descending order among stored entries
        if (gi == DEPTH - 1) begin : g_ord_tail
            assign w_pair_ok[gi] = 1'b1;
        end else begin : g_ord
            assign w_pair_ok[gi] = !w_occ[gi+1] ||
                (w_entry[gi].item_priority >= w_entry[gi+1].item_priority);
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.rem_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_occ_ext = {{OCC_W{1'b0}}, n_count};

    always_comb begin
        n_result               = '0;
        n_result.occupancy     = w_occ_ext[OCC_W-1:0];
        if (i_cmd.kind == KIND_INSERT) begin
            n_result.status = w_full ? ST_FULL : ST_DONE;
        end else if (w_empty) begin
            n_result.status = ST_EMPTY;
        end else begin
            n_result.status        = ST_DONE;
            n_result.head_value    = w_entry[0].item_value;
            n_result.head_priority = w_entry[0].item_priority;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_busy   <= 1'b0;
            r_strobe <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    // Fill level never passes the number of cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // Every accepted item yields a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_strobe)
        else $error("accepted item without result");

    // Stored entries stay in descending priority order
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &w_pair_ok)
        else $error("queue out of priority order");

    // A full-queue status only when the queue really was full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.kind == KIND_INSERT) && !w_full) |=>
            (r_result.status == ST_DONE))
        else $error("insert into non-full queue flagged");

endmodule

### design/spq_cell.sv
// One queue slot: holds an entry and shifts toward head or tail.
module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,
    input  t_entry    i_new,
    input  t_entry    i_left,
    input  t_entry    i_right,
    input  logic      i_left_flag,
    output logic      o_flag,
    output t_entry    o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // Flag: new entry belongs at or ahead of this slot.
    // Equal priority stays ahead of the new entry (FIFO among equals).
    assign o_flag  = !i_occ || (r_entry.item_priority < i_new.item_priority);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.rem_en) begin
            n_entry = i_right;
        end else if (i_ctl.ins_en && o_flag) begin
            if (i_left_flag) begin
                n_entry = i_left;
            end else begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### bench/tb_sorted_priority_queue.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted priority queue: random and directed commands.
module tb_sorted_priority_queue
    import spq_pkg::*;
();

    localparam int DEPTH       = 16;
    localparam int IDLE_LIMIT  = 2000;  // cycles with no accepted item or result
    localparam int DRAIN_TAIL  = 8;     // extra cycles after the last result
    localparam int RANDOM_CMDS = 628;
    localparam int PRINT_CAP   = 40;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    sorted_priority_queue #(
        .DEPTH (DEPTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    // Commands waiting to be driven, and results the queue still owes us.
    t_cmd    cmd_backlog[$];
    t_result owed_results[$];
    int      mismatch_count = 0;
    int      idle_cycles    = 0;

    // Shadow copy of the queue contents, head at index 0.
    t_entry      shadow_entries[DEPTH];
    int          shadow_count = 0;

    wire cmd_accept = start && !busy;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Apply one command to the shadow queue and return the result it must produce.
    function automatic t_result serve_command(input t_cmd c);
        t_result     r;
        int          pos;
        r = '0;
        if (c.kind == KIND_INSERT) begin
            if (shadow_count >= DEPTH) begin
                r.status = ST_FULL;   // dropped, contents untouched
            end else begin
                // Land behind every entry of greater or equal priority: ties stay FIFO.
                pos = 0;
                while (pos < shadow_count && shadow_entries[pos].item_priority >= c.item_priority)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                    shadow_entries[i] = shadow_entries[i-1];
                shadow_entries[pos].item_value    = c.item_value;
                shadow_entries[pos].item_priority = c.item_priority;
                shadow_count++;
                r.status = ST_DONE;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.status        = ST_DONE;
                r.head_value    = shadow_entries[0].item_value;
                r.head_priority = shadow_entries[0].item_priority;
                for (int i = 1; i < shadow_count; i++)
                    shadow_entries[i-1] = shadow_entries[i];
                shadow_count--;
            end
        end
        r.occupancy = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic queue_command(input t_kind k, input logic [VALUE_W-1:0] v,
                                 input logic [PRIO_W-1:0] p);
        t_cmd c;
        c.kind          = k;
        c.item_value    = v;
        c.item_priority = p;
        cmd_backlog.push_back(c);
    endtask

    // Driver: bursts of back-to-back commands separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin : driver
        logic next_start;
        next_start = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // item not taken yet, hold it
        end else begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_backlog.size() != 0) begin
                i_cmd <= cmd_backlog.pop_front();
                next_start = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 7))
                        0, 1, 2: gap_left = 0;                      // keep streaming
                        7:       gap_left = $urandom_range(10, 25);  // long pause
                        default: gap_left = $urandom_range(1, 5);
                    endcase
                end
            end
            start <= next_start;
        end
    end

    // Monitor: check the result of this edge, then predict for the item taken here.
    // The result of an item never shows up on the edge that accepts it.
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (o_strobe) begin
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", o_result));
            end else begin
                want = owed_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_result.status, want.status));
                if (o_result.head_value !== want.head_value)
                    report_mismatch($sformatf("head_value %0d, want %0d",
                                              o_result.head_value, want.head_value));
                if (o_result.head_priority !== want.head_priority)
                    report_mismatch($sformatf("head_priority %0d, want %0d",
                                              o_result.head_priority, want.head_priority));
                if (o_result.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, want %0d",
                                              o_result.occupancy, want.occupancy));
            end
        end
        if (i_rst_n && cmd_accept)
            owed_results.push_back(serve_command(i_cmd));
    end

    // Watchdog: nothing moving for too long means the queue has hung.
    always @(posedge i_clk) begin : watchdog
        if (cmd_accept || o_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_sorted_priority_queue NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        int          n;
        int          seg_len;
        int          bias;
        int          pmode;
        logic [7:0]  pri;
        t_kind       k;

        // Directed: remove while empty first.
        queue_command(KIND_REMOVE, 32'h0000_0000, 8'h00);
        // Fill to capacity with value extremes, priority extremes and ties.
        queue_command(KIND_INSERT, 32'h8000_0000, 8'h10);
        queue_command(KIND_INSERT, 32'h7FFF_FFFF, 8'hFF);
        queue_command(KIND_INSERT, 32'h0000_0000, 8'h00);
        queue_command(KIND_INSERT, 32'hFFFF_FFFF, 8'h10);
        queue_command(KIND_INSERT, 32'h5555_5555, 8'h10);
        queue_command(KIND_INSERT, 32'hAAAA_AAAA, 8'h55);
        queue_command(KIND_INSERT, 32'h0000_0001, 8'hAA);
        queue_command(KIND_INSERT, 32'h1234_5678, 8'hFF);
        queue_command(KIND_INSERT, 32'hDEAD_BEEF, 8'h00);
        queue_command(KIND_INSERT, 32'h0F0F_0F0F, 8'h80);
        queue_command(KIND_INSERT, 32'hF0F0_F0F0, 8'h7F);
        queue_command(KIND_INSERT, 32'h0000_00FF, 8'h01);
        queue_command(KIND_INSERT, 32'hFFFF_FF00, 8'hFE);
        queue_command(KIND_INSERT, 32'h3333_3333, 8'h10);
        queue_command(KIND_INSERT, 32'hCCCC_CCCC, 8'h40);
        queue_command(KIND_INSERT, 32'h6666_6666, 8'h20);
        // Full: this one must be dropped.
        queue_command(KIND_INSERT, 32'h7FFF_FFFF, 8'hFF);
        repeat (4) queue_command(KIND_REMOVE, 32'hFFFF_FFFF, 8'hFF);

        // Random: segments that lean toward filling, draining or neither,
        // so full and empty are hit many times.
        n = 0;
        while (n < RANDOM_CMDS) begin
            seg_len = $urandom_range(10, 40);
            bias    = $urandom_range(0, 2);
            pmode   = $urandom_range(0, 3);
            for (int j = 0; j < seg_len && n < RANDOM_CMDS; j++) begin
                case (bias)
                    0:       k = ($urandom_range(0, 99) < 85) ? KIND_INSERT : KIND_REMOVE;
                    1:       k = ($urandom_range(0, 99) < 15) ? KIND_INSERT : KIND_REMOVE;
                    default: k = ($urandom_range(0, 1) == 0)  ? KIND_INSERT : KIND_REMOVE;
                endcase
                case (pmode)
                    0:       pri = 8'($urandom_range(0, 3));          // many ties
                    1:       pri = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
                    default: pri = 8'($urandom_range(0, 255));
                endcase
                queue_command(k, $urandom, pri);
                n++;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start)
            @(posedge i_clk);
        while (owed_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (owed_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", owed_results.size()));

        if (mismatch_count == 0) begin
            $display("tb_sorted_priority_queue OK");
        end else begin
            $display("tb_sorted_priority_queue NOT OK");
        end
        $finish;
    end

endmodule

### files.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
bench/tb_sorted_priority_queue.sv
